>>> hdl/sgc_pkg.sv
// sgc_pkg: shared types and constants of the subset gcd counter
// used by sgc_gcd, subset_gcd_count and subset_gcd_count_test; no dependencies
package sgc_pkg;
	localparam int VALUE_LIMIT = 1024;
	localparam int IDX_W = $clog2(VALUE_LIMIT);
	localparam int VAL_W = 10;
	localparam int CNT_W = 30;
	localparam int SHIFT_W = $clog2(VAL_W);
	localparam logic [CNT_W:0] COUNT_MODULUS = 31'd1000000007;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RDJ,
		ST_LATJ,
		ST_GCD,
		ST_RDG,
		ST_ADD,
		ST_RDGOAL,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic done;
		logic [VAL_W-1:0] g;
	} gcd_res_t;
endpackage

>>> hdl/sgc_gcd.sv
// sgc_gcd: multi-cycle binary gcd unit, one halving or subtract step per cycle
// depends on sgc_pkg
module sgc_gcd (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [sgc_pkg::VAL_W-1:0] a,
	input  logic [sgc_pkg::VAL_W-1:0] b,
	output sgc_pkg::gcd_res_t res
);
	logic run_q;
	logic [sgc_pkg::VAL_W-1:0] a_q, b_q;
	logic [sgc_pkg::SHIFT_W-1:0] k_q;
	logic fin;

	assign fin = run_q && (a_q == '0 || b_q == '0);
	assign res.done = fin;
	assign res.g = (a_q | b_q) << k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else if (start) begin
			run_q <= 1'b1;
		end else if (fin) begin
			run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			k_q <= '0;
		end else if (run_q && !fin) begin
			priority if (!a_q[0] && !b_q[0]) begin
				a_q <= a_q >> 1;
				b_q <= b_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!a_q[0]) begin
				a_q <= a_q >> 1;
			end else if (!b_q[0]) begin
				b_q <= b_q >> 1;
			end else if (a_q >= b_q) begin
				a_q <= a_q - b_q;
			end else begin
				b_q <= b_q - a_q;
			end
		end
	end
endmodule

>>> hdl/sgc_ram.sv
// sgc_ram: generic single-port ram with registered read
// no dependencies
module sgc_ram #(
	parameter int WIDTH = 30,
	parameter int DEPTH = 1024
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

>>> hdl/subset_gcd_count.sv
// subset_gcd_count: counts subsets of a value sequence whose gcd equals goal_gcd
// depends on sgc_pkg, sgc_gcd, sgc_ram
//
// usage: a value transfer happens when start is high and busy is low. each
// value folds a 1024-entry count table held in one ram: entries 1..1023 are
// visited in ascending order and entry 0 last, each adding its count to the
// entry at gcd(index, value); the in-place order keeps every read on the old
// count. per entry: ram read, a binary gcd in the shared gcd unit, a ram
// read and a modular write back; the run time of each value is set by the
// gcd unit and the single ram port.
// with last_item high, the count at goal_gcd is shown on subset_count with
// result_valid high for one cycle, after the fold and a ram read of the goal
// entry, and the table is then cleared. after reset the same clearing pass
// runs with busy high; apb writes are taken at any time.
// the receiver cannot stall; results are never held.
module subset_gcd_count (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  logic start,
	output logic busy,
	input  logic [sgc_pkg::VAL_W-1:0] value,
	input  logic last_item,
	output logic result_valid,
	output logic [sgc_pkg::CNT_W-1:0] subset_count
);
	sgc_pkg::state_t state_q, state_nx;
	logic [sgc_pkg::VAL_W-1:0] goal_q, val_q;
	logic last_q;
	logic [sgc_pkg::IDX_W-1:0] j_q, g_q;
	logic [sgc_pkg::CNT_W-1:0] cj_q;
	sgc_pkg::gcd_res_t gres;
	logic gstart, we;
	logic [sgc_pkg::IDX_W-1:0] addr;
	logic [sgc_pkg::CNT_W-1:0] wdata, rdata;
	logic [sgc_pkg::CNT_W:0] sum, sum_red;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {22'd0, goal_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_q <= 10'd1;
		end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
			goal_q <= pwdata[sgc_pkg::VAL_W-1:0];
		end
	end

	sgc_gcd u_gcd (
		.clk(clk), .arst_n(arst_n), .start(gstart),
		.a(j_q), .b(val_q), .res(gres)
	);

	sgc_ram #(.WIDTH(sgc_pkg::CNT_W), .DEPTH(sgc_pkg::VALUE_LIMIT)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	assign sum = {1'b0, rdata} + {1'b0, cj_q};
	assign sum_red = (sum >= sgc_pkg::COUNT_MODULUS) ? sum - sgc_pkg::COUNT_MODULUS : sum;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			sgc_pkg::ST_CLEAR: if (j_q == '1) state_nx = sgc_pkg::ST_IDLE;
			sgc_pkg::ST_IDLE: if (start) state_nx = sgc_pkg::ST_RDJ;
			sgc_pkg::ST_RDJ: state_nx = sgc_pkg::ST_LATJ;
			sgc_pkg::ST_LATJ: state_nx = sgc_pkg::ST_GCD;
			sgc_pkg::ST_GCD: if (gres.done) state_nx = sgc_pkg::ST_RDG;
			sgc_pkg::ST_RDG: state_nx = sgc_pkg::ST_ADD;
			sgc_pkg::ST_ADD: begin
				if (j_q != '0) state_nx = sgc_pkg::ST_RDJ;
				else if (last_q) state_nx = sgc_pkg::ST_RDGOAL;
				else state_nx = sgc_pkg::ST_IDLE;
			end
			sgc_pkg::ST_RDGOAL: state_nx = sgc_pkg::ST_OUT;
			sgc_pkg::ST_OUT: state_nx = sgc_pkg::ST_CLEAR;
			default: state_nx = sgc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy = (state_q != sgc_pkg::ST_IDLE);
		gstart = 1'b0;
		we = 1'b0;
		addr = j_q;
		wdata = sum_red[sgc_pkg::CNT_W-1:0];
		result_valid = 1'b0;
		subset_count = rdata;
		unique case (state_q)
			sgc_pkg::ST_CLEAR: begin
				we = 1'b1;
				wdata = (j_q == '0) ? 30'd1 : 30'd0;
			end
			sgc_pkg::ST_LATJ: gstart = 1'b1;
			sgc_pkg::ST_RDG, sgc_pkg::ST_ADD: begin
				addr = g_q;
				we = (state_q == sgc_pkg::ST_ADD);
			end
			sgc_pkg::ST_RDGOAL: addr = goal_q;
			sgc_pkg::ST_OUT: result_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sgc_pkg::ST_CLEAR;
			j_q <= '0;
		end else begin
			state_q <= state_nx;
			unique case (state_q)
				sgc_pkg::ST_CLEAR: j_q <= j_q + 1'b1;
				sgc_pkg::ST_IDLE: j_q <= 10'd1;
				sgc_pkg::ST_ADD: j_q <= j_q + 1'b1;
				sgc_pkg::ST_OUT: j_q <= '0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == sgc_pkg::ST_IDLE && start) begin
			val_q <= value;
			last_q <= last_item;
		end
		if (state_q == sgc_pkg::ST_LATJ) cj_q <= rdata;
		if (state_q == sgc_pkg::ST_GCD && gres.done) g_q <= gres.g;
	end

	a_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(state_q) == sgc_pkg::ST_RDGOAL)
		else $error("result strobe without goal read");
	a_write: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == sgc_pkg::ST_ADD || state_q == sgc_pkg::ST_CLEAR))
		else $error("table write outside add or clear");
	a_gcd: assert property (@(posedge clk) disable iff (!arst_n)
		gres.done |-> state_q == sgc_pkg::ST_GCD)
		else $error("gcd finished outside wait state");
	a_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sgc_pkg::ST_ADD) |=> $past(sum_red) < sgc_pkg::COUNT_MODULUS)
		else $error("modular add out of range");
endmodule

>>> dv/subset_gcd_count_test.sv
// subset_gcd_count_test: self-checking bench for subset_gcd_count
// drives value sequences and apb goal writes, predicts each subset count
// depends on sgc_pkg and subset_gcd_count
`timescale 1ns / 100ps

module subset_gcd_count_test;
	localparam logic [2:0] GOAL_ADDR = 3'd0;
	localparam int STALL_LIMIT = 400000;
	localparam int ITEM_TOTAL = 290;
	localparam int CALM_TAIL = 40;

	class gcd_count_board;
		logic [sgc_pkg::CNT_W-1:0] counts[sgc_pkg::VALUE_LIMIT];
		logic [sgc_pkg::VAL_W-1:0] goal;
		logic [sgc_pkg::CNT_W-1:0] expected_counts[$];
		int mismatches;

		function new();
			goal = 1;
			mismatches = 0;
			clear_counts();
		endfunction

		function void clear_counts();
			foreach (counts[i])
				counts[i] = '0;
			counts[0] = 1;
		endfunction

		function int gcd_of(int a, int b);
			int r;
			while (b != 0) begin
				r = a % b;
				a = b;
				b = r;
			end
			return a;
		endfunction

		function void fold_value(logic [sgc_pkg::VAL_W-1:0] v, logic last);
			logic [sgc_pkg::CNT_W-1:0] folded[sgc_pkg::VALUE_LIMIT];
			logic [sgc_pkg::CNT_W:0] sum;
			int g;
			folded = counts;
			for (int j = 0; j < sgc_pkg::VALUE_LIMIT; j++) begin
				g = gcd_of(j, int'(v));
				if (g < sgc_pkg::VALUE_LIMIT) begin
					sum = {1'b0, folded[g]} + {1'b0, counts[j]};
					if (sum >= sgc_pkg::COUNT_MODULUS)
						sum = sum - sgc_pkg::COUNT_MODULUS;
					folded[g] = sum[sgc_pkg::CNT_W-1:0];
				end
			end
			counts = folded;
			if (last) begin
				expected_counts.insert(expected_counts.size(), counts[goal]);
				clear_counts();
			end
		endfunction

		function void check_count(logic [sgc_pkg::CNT_W-1:0] actual);
			logic [sgc_pkg::CNT_W-1:0] want;
			if (expected_counts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer: subset_count=%0d", actual);
				return;
			end
			want = expected_counts.pop_front();
			if (actual !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("subset_count mismatch: expected %0d, got %0d", want, actual);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic start;
	logic busy;
	logic [sgc_pkg::VAL_W-1:0] value;
	logic last_item;
	logic result_valid;
	logic [sgc_pkg::CNT_W-1:0] subset_count;

	gcd_count_board board;
	int accepted;
	int sent;
	int stall_cycles;

	subset_gcd_count dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .value(value), .last_item(last_item),
		.result_valid(result_valid), .subset_count(subset_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			stall_cycles++;
			if (start && !busy) begin
				board.fold_value(value, last_item);
				accepted++;
				stall_cycles = 0;
			end
			if (result_valid) begin
				board.check_count(subset_count);
				stall_cycles = 0;
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("[subset_gcd_count] ERROR");
				$finish;
			end
		end
	end

	task automatic write_goal(logic [sgc_pkg::VAL_W-1:0] g);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = GOAL_ADDR;
		pwdata = 32'(g);
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		board.goal = g;
	endtask

	task automatic wait_idle();
		while (board.expected_counts.size() != 0 || busy)
			@(negedge clk);
	endtask

	task automatic send_value(logic [sgc_pkg::VAL_W-1:0] v, logic last);
		int seen;
		if (sent < ITEM_TOTAL - CALM_TAIL && $urandom_range(0, 3) == 0) begin
			start = 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		start = 1'b1;
		value = v;
		last_item = last;
		seen = accepted;
		do @(negedge clk); while (accepted == seen);
		sent++;
	endtask

	function automatic logic [sgc_pkg::VAL_W-1:0] pick_value(logic [sgc_pkg::VAL_W-1:0] g);
		int pick;
		if ($urandom_range(0, 29) == 0)
			pick = 0;
		else if (g != 0 && $urandom_range(0, 9) < 7)
			pick = int'(g) * int'($urandom_range(1, 1023 / int'(g)));
		else
			pick = int'($urandom_range(1, 1023));
		return pick[sgc_pkg::VAL_W-1:0];
	endfunction

	task automatic send_sequence(logic [sgc_pkg::VAL_W-1:0] g);
		int n;
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++)
			send_value(pick_value(g), i == n - 1);
	endtask

	initial begin
		logic [sgc_pkg::VAL_W-1:0] g;
		int seq_count;
		int pick;
		board = new();
		accepted = 0;
		sent = 0;
		stall_cycles = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		value = '0;
		last_item = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait_idle();

		// directed: reset goal, extremes, zero value, shared factors
		send_value(10'd1023, 1'b1);
		send_value(10'd1, 1'b1);
		send_value(10'd0, 1'b1);
		send_value(10'd6, 1'b0);
		send_value(10'd10, 1'b0);
		send_value(10'd15, 1'b1);
		send_value(10'd512, 1'b0);
		send_value(10'd682, 1'b0);
		send_value(10'd341, 1'b1);
		start = 1'b0;
		wait_idle();
		write_goal(10'd1023);
		send_value(10'd1023, 1'b0);
		send_value(10'd1023, 1'b1);
		start = 1'b0;
		wait_idle();
		write_goal(10'd0);
		send_value(10'd0, 1'b0);
		send_value(10'd0, 1'b1);
		send_value(10'd7, 1'b1);
		start = 1'b0;
		wait_idle();
		write_goal(10'd2);
		send_value(10'd4, 1'b0);
		send_value(10'd6, 1'b0);
		send_value(10'd0, 1'b0);
		send_value(10'd1022, 1'b1);

		seq_count = 0;
		while (sent < ITEM_TOTAL) begin
			if (seq_count % 8 == 0) begin
				start = 1'b0;
				wait_idle();
				case ($urandom_range(0, 5))
					0: pick = 1;
					1: pick = 1023;
					2: pick = 0;
					3: pick = int'($urandom_range(2, 12));
					default: pick = int'($urandom_range(1, 1023));
				endcase
				g = pick[sgc_pkg::VAL_W-1:0];
				write_goal(g);
			end
			send_sequence(board.goal);
			seq_count++;
		end
		start = 1'b0;
		wait_idle();
		repeat (1200) @(negedge clk);
		if (board.mismatches == 0 && board.expected_counts.size() == 0)
			$display("[subset_gcd_count] OK");
		else
			$display("[subset_gcd_count] ERROR");
		$finish;
	end
endmodule
